FILE: design/bst_pkg.sv
// shared types, codes and character helpers for the byte stream tokenizer
package bst_pkg;

  localparam int BST_NUM_KEYWORDS = 16;
  localparam int BST_ID_LEN       = 32;
  localparam int KW_SLOT          = 32;
  localparam int QDEPTH           = 4;

  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SUB   = 8'd26;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_QUOTE = 8'h22;

  // token codes
  localparam logic [5:0] TOK_NONE   = 6'd0;
  localparam logic [5:0] TOK_IDENT  = 6'd1;
  localparam logic [5:0] TOK_NUMBER = 6'd2;
  localparam logic [5:0] TOK_STRING = 6'd3;
  localparam logic [5:0] TOK_NE     = 6'd4;
  localparam logic [5:0] TOK_LE     = 6'd5;
  localparam logic [5:0] TOK_LT     = 6'd6;
  localparam logic [5:0] TOK_PLUS   = 6'd7;
  localparam logic [5:0] TOK_STAR   = 6'd8;
  localparam logic [5:0] TOK_MINUS  = 6'd9;
  localparam logic [5:0] TOK_EQ     = 6'd10;
  localparam logic [5:0] TOK_COMMA  = 6'd11;
  localparam logic [5:0] TOK_CARET  = 6'd12;
  localparam logic [5:0] TOK_LBRACK = 6'd13;
  localparam logic [5:0] TOK_RBRACK = 6'd14;
  localparam logic [5:0] TOK_GE     = 6'd15;
  localparam logic [5:0] TOK_GT     = 6'd16;
  localparam logic [5:0] TOK_HASH   = 6'd17;
  localparam logic [5:0] TOK_COLON  = 6'd18;
  localparam logic [5:0] TOK_SEMI   = 6'd19;
  localparam logic [5:0] TOK_SLASH  = 6'd20;
  localparam logic [5:0] TOK_DOT    = 6'd21;
  localparam logic [5:0] TOK_LPAREN = 6'd22;
  localparam logic [5:0] TOK_RPAREN = 6'd23;
  localparam logic [5:0] TOK_EOLN   = 6'd24;
  localparam logic [5:0] TOK_EOF    = 6'd25;

  // result kinds
  localparam logic RES_TEXT  = 1'b0;
  localparam logic RES_TOKEN = 1'b1;

  // config register index
  localparam int REG_KEYWORD_COUNT = 0;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_EOI  = 2'd1,
    KIND_KW   = 2'd2,
    KIND_NONE = 2'd3
  } item_kind_t;

  typedef enum logic [3:0] {
    CL_SPACE,
    CL_ALPHA,
    CL_DIGIT,
    CL_UNDER,
    CL_LT,
    CL_GT,
    CL_EQ,
    CL_QUOTE,
    CL_OTHER
  } char_class_t;

  // one classified item as it travels from front to back
  typedef struct packed {
    item_kind_t  kind;
    logic [7:0]  ch;
    char_class_t cls;
    logic [5:0]  op;
    logic [3:0]  kw_entry;
    logic [4:0]  kw_pos;
    logic [5:0]  kw_symbol;
  } bst_item_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    if (c == 8'h20) r = CL_SPACE;
    else if ((c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)) r = CL_ALPHA;
    else if (c >= 8'h30 && c <= 8'h39) r = CL_DIGIT;
    else if (c == CH_UNDER) r = CL_UNDER;
    else if (c == 8'h3C) r = CL_LT;
    else if (c == 8'h3E) r = CL_GT;
    else if (c == 8'h3D) r = CL_EQ;
    else if (c == CH_QUOTE) r = CL_QUOTE;
    else r = CL_OTHER;
    return r;
  endfunction

  function automatic logic [5:0] single_op(input logic [7:0] c);
    logic [5:0] r;
    unique case (c)
      8'h2B:   r = TOK_PLUS;
      8'h2A:   r = TOK_STAR;
      8'h2D:   r = TOK_MINUS;
      8'h3D:   r = TOK_EQ;
      8'h2C:   r = TOK_COMMA;
      8'h5E:   r = TOK_CARET;
      8'h5B:   r = TOK_LBRACK;
      8'h5D:   r = TOK_RBRACK;
      8'h23:   r = TOK_HASH;
      8'h3A:   r = TOK_COLON;
      8'h3B:   r = TOK_SEMI;
      8'h2F:   r = TOK_SLASH;
      8'h2E:   r = TOK_DOT;
      8'h28:   r = TOK_LPAREN;
      8'h29:   r = TOK_RPAREN;
      CH_CR:   r = TOK_EOLN;
      CH_SUB:  r = TOK_EOF;
      default: r = TOK_NONE;
    endcase
    return r;
  endfunction

endpackage

FILE: design/bst_front.sv
// input side: accepts items, folds line ends and classifies bytes
module bst_front import bst_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] kind,
  input  logic [7:0] byte_req,
  input  logic [3:0] kw_entry,
  input  logic [4:0] kw_pos,
  input  logic [5:0] kw_symbol,
  input  logic       q_full,
  output logic       push,
  output bst_item_t  push_item
);

  logic       cr_pending;
  logic       acc;
  logic       drop;
  logic [7:0] ch_map;
  item_kind_t k;

  assign k        = item_kind_t'(kind);
  assign in_ready = !q_full;
  assign acc      = in_valid && in_ready;

  // lf right after cr vanishes, lf alone acts as cr; keyword characters pass as is
  assign drop   = (k == KIND_NONE) || (k == KIND_BYTE && cr_pending && byte_req == CH_LF);
  assign ch_map = (k == KIND_BYTE && byte_req == CH_LF) ? CH_CR : byte_req;
  assign push   = acc && !drop;

  always_comb begin
    push_item.kind      = k;
    push_item.ch        = ch_map;
    push_item.cls       = classify(ch_map);
    push_item.op        = single_op(ch_map);
    push_item.kw_entry  = kw_entry;
    push_item.kw_pos    = kw_pos;
    push_item.kw_symbol = kw_symbol;
  end

  // track a cr so a following lf can be dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cr_pending <= 1'b0;
    end else if (acc) begin
      if (k == KIND_BYTE) begin
        cr_pending <= !drop && (byte_req == CH_CR);
      end else if (k == KIND_EOI) begin
        cr_pending <= 1'b0;
      end
    end
  end

endmodule

FILE: design/bst_queue.sv
// short fifo between classifier and scanner
module bst_queue import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  bst_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output bst_item_t head
);

  localparam int PW = $clog2(QDEPTH);

  bst_item_t       mem [QDEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full       = (count == (PW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

FILE: design/bst_back.sv
// scanner: token state, keyword table, keyword compare and output register
module bst_back import bst_pkg::*; #(
  parameter int NUM_KEYWORDS = BST_NUM_KEYWORDS,
  parameter int ID_LEN       = BST_ID_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [4:0]  kw_count,
  input  logic        head_valid,
  input  bst_item_t   hd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [5:0]  token,
  output logic [31:0] value,
  output logic [7:0]  text_char,
  output logic        last
);

  localparam int KW_IW = (NUM_KEYWORDS > 1) ? $clog2(NUM_KEYWORDS) : 1;
  localparam int EW    = $clog2(NUM_KEYWORDS + 1);
  localparam int TW    = $clog2(ID_LEN);
  localparam int LW    = $clog2(ID_LEN + 1);

  typedef enum logic [2:0] {
    M_IDLE, M_IDENT, M_NUMBER, M_STRING, M_STRQ, M_LT, M_GT
  } mode_t;

  typedef enum logic [2:0] {
    B_DECODE, B_FRESH, B_KW_RD, B_KW_CMP, B_KW_EMIT
  } bstate_t;

  typedef struct packed {
    logic        rk;
    logic [5:0]  tok;
    logic [31:0] val;
    logic [7:0]  ch;
    logic        lst;
  } res_t;

  // storage
  logic [7:0] txt_mem  [ID_LEN];
  logic [7:0] kw_mem   [NUM_KEYWORDS * KW_SLOT];
  logic [5:0] code_mem [NUM_KEYWORDS];

  bstate_t     st, st_next;
  mode_t       mode, mode_next;
  logic [LW-1:0] ident_len, ident_len_next;
  logic [31:0] num_acc, num_acc_next;
  logic [EW-1:0] e, e_next;
  logic [4:0]  p, p_next;
  logic [5:0]  code, code_next;

  logic        emit;
  res_t        res;
  logic        can_emit;
  logic        txt_we;
  logic [TW-1:0] txt_waddr;
  logic        kw_we;
  logic        kw_ok;
  logic [EW-1:0] kw_n;
  logic        cont;
  logic        fresh_emits;
  logic [5:0]  close_tok;
  logic [7:0]  kc, ic, text_q;
  logic [5:0]  code_q;
  logic [31:0] num_step;

  assign can_emit = !out_valid || out_ready;
  assign kw_ok    = (32'(hd.kw_entry) < NUM_KEYWORDS);
  assign kw_n     = (32'(kw_count) > NUM_KEYWORDS) ? EW'(NUM_KEYWORDS) : EW'(kw_count);
  assign num_step = (num_acc << 3) + (num_acc << 1) + 32'(hd.ch) - 32'(CH_ZERO);
  assign ic       = (32'(p) < 32'(ident_len)) ? text_q : 8'd0;

  // byte continues the open token without closing it
  always_comb begin
    cont = 1'b0;
    if (hd.kind == KIND_BYTE) begin
      unique case (mode)
        M_IDENT:  cont = (hd.cls == CL_ALPHA) || (hd.cls == CL_DIGIT) || (hd.cls == CL_UNDER);
        M_NUMBER: cont = (hd.cls == CL_ALPHA) || (hd.cls == CL_DIGIT);
        M_STRING: cont = 1'b1;
        M_STRQ:   cont = (hd.cls == CL_QUOTE);
        M_LT:     cont = (hd.cls == CL_GT) || (hd.cls == CL_EQ);
        M_GT:     cont = (hd.cls == CL_EQ);
        default:  cont = 1'b0;
      endcase
    end
  end

  // whether scanning from idle gives a result after a close
  assign fresh_emits = (hd.kind == KIND_EOI) ||
                       !((hd.cls == CL_SPACE) || (hd.cls == CL_DIGIT) || (hd.cls == CL_LT) ||
                         (hd.cls == CL_GT) || (hd.cls == CL_QUOTE));

  always_comb begin
    unique case (mode)
      M_NUMBER:        close_tok = TOK_NUMBER;
      M_STRING, M_STRQ: close_tok = TOK_STRING;
      M_LT:            close_tok = TOK_LT;
      M_GT:            close_tok = TOK_GT;
      default:         close_tok = TOK_NONE;
    endcase
  end

  // scanner control
  always_comb begin
    st_next        = st;
    mode_next      = mode;
    ident_len_next = ident_len;
    num_acc_next   = num_acc;
    e_next         = e;
    p_next         = p;
    code_next      = code;
    pop            = 1'b0;
    emit           = 1'b0;
    res            = '0;
    txt_we         = 1'b0;
    txt_waddr      = ident_len[TW-1:0];
    kw_we          = 1'b0;
    unique case (st)
      B_DECODE: begin
        if (head_valid) begin
          if (hd.kind == KIND_KW) begin
            kw_we = kw_ok;
            pop   = 1'b1;
          end else if (cont) begin
            unique case (mode)
              M_IDENT: begin
                if (32'(ident_len) < ID_LEN) begin
                  if (can_emit) begin
                    emit           = 1'b1;
                    res            = '{RES_TEXT, TOK_IDENT, 32'd0, hd.ch, 1'b1};
                    txt_we         = 1'b1;
                    ident_len_next = ident_len + 1'b1;
                    pop            = 1'b1;
                  end
                end else begin
                  pop = 1'b1;
                end
              end
              M_NUMBER: begin
                num_acc_next = num_step;
                pop          = 1'b1;
              end
              M_STRING: begin
                if (hd.cls == CL_QUOTE) begin
                  mode_next = M_STRQ;
                  pop       = 1'b1;
                end else if (can_emit) begin
                  emit = 1'b1;
                  res  = '{RES_TEXT, TOK_STRING, 32'd0, hd.ch, 1'b1};
                  pop  = 1'b1;
                end
              end
              M_STRQ: begin
                if (can_emit) begin
                  emit      = 1'b1;
                  res       = '{RES_TEXT, TOK_STRING, 32'd0, hd.ch, 1'b1};
                  mode_next = M_STRING;
                  pop       = 1'b1;
                end
              end
              M_LT: begin
                if (can_emit) begin
                  emit      = 1'b1;
                  res       = '{RES_TOKEN, (hd.cls == CL_GT) ? TOK_NE : TOK_LE, 32'd0, 8'd0,
                                1'b1};
                  mode_next = M_IDLE;
                  pop       = 1'b1;
                end
              end
              M_GT: begin
                if (can_emit) begin
                  emit      = 1'b1;
                  res       = '{RES_TOKEN, TOK_GE, 32'd0, 8'd0, 1'b1};
                  mode_next = M_IDLE;
                  pop       = 1'b1;
                end
              end
              default: ;
            endcase
          end else if (mode == M_IDENT) begin
            // identifier ends: search the keyword table
            e_next = '0;
            p_next = '0;
            if (kw_n == '0) begin
              code_next = TOK_IDENT;
              st_next   = B_KW_EMIT;
            end else begin
              st_next = B_KW_RD;
            end
          end else if (mode != M_IDLE) begin
            if (can_emit) begin
              emit      = 1'b1;
              res       = '{RES_TOKEN, close_tok, (mode == M_NUMBER) ? num_acc : 32'd0, 8'd0,
                            !fresh_emits};
              mode_next = M_IDLE;
              st_next   = B_FRESH;
            end
          end else begin
            st_next = B_FRESH;
          end
        end
      end
      B_FRESH: begin
        if (hd.kind == KIND_EOI) begin
          if (can_emit) begin
            emit    = 1'b1;
            res     = '{RES_TOKEN, TOK_EOF, 32'd0, 8'd0, 1'b1};
            pop     = 1'b1;
            st_next = B_DECODE;
          end
        end else begin
          unique case (hd.cls)
            CL_SPACE: begin
              pop     = 1'b1;
              st_next = B_DECODE;
            end
            CL_ALPHA: begin
              if (can_emit) begin
                emit           = 1'b1;
                res            = '{RES_TEXT, TOK_IDENT, 32'd0, hd.ch, 1'b1};
                txt_we         = 1'b1;
                txt_waddr      = '0;
                ident_len_next = LW'(1);
                mode_next      = M_IDENT;
                pop            = 1'b1;
                st_next        = B_DECODE;
              end
            end
            CL_DIGIT: begin
              num_acc_next = 32'(hd.ch) - 32'(CH_ZERO);
              mode_next    = M_NUMBER;
              pop          = 1'b1;
              st_next      = B_DECODE;
            end
            CL_LT: begin
              mode_next = M_LT;
              pop       = 1'b1;
              st_next   = B_DECODE;
            end
            CL_GT: begin
              mode_next = M_GT;
              pop       = 1'b1;
              st_next   = B_DECODE;
            end
            CL_QUOTE: begin
              mode_next = M_STRING;
              pop       = 1'b1;
              st_next   = B_DECODE;
            end
            default: begin
              if (can_emit) begin
                emit    = 1'b1;
                res     = '{RES_TOKEN, hd.op, 32'd0, 8'd0, 1'b1};
                pop     = 1'b1;
                st_next = B_DECODE;
              end
            end
          endcase
        end
      end
      B_KW_RD: begin
        st_next = B_KW_CMP;
      end
      B_KW_CMP: begin
        // one character of one entry per pass
        if (kc != ic || (kc != 8'd0 && p == 5'(KW_SLOT - 1) &&
                         32'(ident_len) != KW_SLOT)) begin
          if (32'(e) + 32'd1 >= 32'(kw_n)) begin
            code_next = TOK_IDENT;
            st_next   = B_KW_EMIT;
          end else begin
            e_next  = e + 1'b1;
            p_next  = '0;
            st_next = B_KW_RD;
          end
        end else if (kc == 8'd0 || p == 5'(KW_SLOT - 1)) begin
          code_next = code_q;
          st_next   = B_KW_EMIT;
        end else begin
          p_next  = p + 1'b1;
          st_next = B_KW_RD;
        end
      end
      B_KW_EMIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          res       = '{RES_TOKEN, code, 32'd0, 8'd0, !fresh_emits};
          mode_next = M_IDLE;
          st_next   = B_FRESH;
        end
      end
      default: st_next = B_DECODE;
    endcase
  end

  // state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= B_DECODE;
      mode      <= M_IDLE;
      ident_len <= '0;
      num_acc   <= '0;
      e         <= '0;
      p         <= '0;
      code      <= TOK_NONE;
      out_valid <= 1'b0;
    end else begin
      st        <= st_next;
      mode      <= mode_next;
      ident_len <= ident_len_next;
      num_acc   <= num_acc_next;
      e         <= e_next;
      p         <= p_next;
      code      <= code_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (emit) begin
      result_kind <= res.rk;
      token       <= res.tok;
      value       <= res.val;
      text_char   <= res.ch;
      last        <= res.lst;
    end
  end

  // identifier text memory
  always_ff @(posedge clk) begin
    if (txt_we) begin
      txt_mem[txt_waddr] <= hd.ch;
    end
    text_q <= txt_mem[TW'(p)];
  end

  // keyword table memories
  always_ff @(posedge clk) begin
    if (kw_we) begin
      kw_mem[{KW_IW'(hd.kw_entry), hd.kw_pos}] <= hd.ch;
      code_mem[KW_IW'(hd.kw_entry)]            <= hd.kw_symbol;
    end
    kc     <= kw_mem[{e[KW_IW-1:0], p}];
    code_q <= code_mem[e[KW_IW-1:0]];
  end

endmodule

FILE: design/byte_stream_tokenizer.sv
// top level of the byte stream tokenizer: config register, front, queue and scanner
//
// Input items (kind, byte_req, kw_entry, kw_pos, kw_symbol) arrive on a
// valid/ready channel; results (result_kind, token, value, text_char, last)
// leave on another. Each input item gives zero to two results; last marks
// the final one. Keyword table writes (kind 2) give no results.
// The front takes one item per cycle into a four-entry queue while it has
// room. The scanner handles one byte at a time, and results leave through
// the output register. When an identifier ends, the keyword compare reads
// one table character at a time through a read and a compare state: up to
// 32 characters per table entry searched, entries limited by
// keyword_count. A stalled receiver holds the output register; the queue
// then fills and in_ready drops. Reset returns the scanner to idle,
// clears the line-end memory and sets keyword_count to zero; the keyword
// table and identifier text are not cleared and must be written first.
// keyword_count is read over the APB port at byte address 0; a write at any address sets it.
module byte_stream_tokenizer import bst_pkg::*; #(
  parameter int NUM_KEYWORDS = BST_NUM_KEYWORDS,
  parameter int ID_LEN       = BST_ID_LEN
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  byte_req,
  input  logic [3:0]  kw_entry,
  input  logic [4:0]  kw_pos,
  input  logic [5:0]  kw_symbol,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        result_kind,
  output logic [5:0]  token,
  output logic [31:0] value,
  output logic [7:0]  text_char,
  output logic        last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic      [4:0] keyword_count;
  logic            q_full;
  logic            push;
  bst_item_t       push_item;
  logic            pop;
  logic            head_valid;
  bst_item_t       head;

  // config register
  assign pready = 1'b1;
  assign prdata = (paddr == 2'(REG_KEYWORD_COUNT)) ? {27'd0, keyword_count} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      keyword_count <= '0;
    end else if (psel && penable && pwrite && pready) begin
      keyword_count <= pwdata[4:0];
    end
  end

  bst_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .kind      (kind),
    .byte_req  (byte_req),
    .kw_entry  (kw_entry),
    .kw_pos    (kw_pos),
    .kw_symbol (kw_symbol),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  bst_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  bst_back #(
    .NUM_KEYWORDS (NUM_KEYWORDS),
    .ID_LEN       (ID_LEN)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .kw_count    (keyword_count),
    .head_valid  (head_valid),
    .hd          (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .token       (token),
    .value       (value),
    .text_char   (text_char),
    .last        (last)
  );

  // text results belong to identifiers or strings and are always final
  a_text_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_TEXT |-> (token == TOK_IDENT || token == TOK_STRING) && last)
    else $error("text result with bad token or last");

  // only number tokens carry a value
  a_value_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && token != TOK_NUMBER |-> value == 32'd0)
    else $error("value set on non-number result");

  // finished tokens carry no text character
  a_token_char: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RES_TOKEN |-> text_char == 8'd0)
    else $error("text char set on token result");

  // the queue never takes a push while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_full |-> !push)
    else $error("push into full queue");

endmodule
